### rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the scanline field sequencer
// Word layouts of the input, result and configuration channels, the phase
// codes and the register indexes.
// ----------------------------------------------------------------------------
package sfs_pkg;

	// register indexes on the configuration channel
	localparam logic [7:0] REG_SYNC_LINES         = 8'd0;
	localparam logic [7:0] REG_TOP_BLANK_LINES    = 8'd1;
	localparam logic [7:0] REG_ACTIVE_LINES       = 8'd2;
	localparam logic [7:0] REG_BOTTOM_BLANK_LINES = 8'd3;

	// register reset values
	localparam logic [7:0] RST_SYNC_LINES         = 8'd3;
	localparam logic [7:0] RST_TOP_BLANK_LINES    = 8'd40;
	localparam logic [7:0] RST_ACTIVE_LINES       = 8'd192;
	localparam logic [7:0] RST_BOTTOM_BLANK_LINES = 8'd27;

	// IR duration counter stops here
	localparam logic [7:0] IR_SAT = 8'hFF;

	// phase codes as they appear in a result word
	localparam logic [1:0] PH_CODE_SYNC   = 2'd0;
	localparam logic [1:0] PH_CODE_TOP    = 2'd1;
	localparam logic [1:0] PH_CODE_ACTIVE = 2'd2;
	localparam logic [1:0] PH_CODE_BOTTOM = 2'd3;

	// field sequencer state
	typedef enum logic [3:0] {
		PH_SYNC   = 4'b0001,
		PH_TOP    = 4'b0010,
		PH_ACTIVE = 4'b0100,
		PH_BOTTOM = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       ir_level;
		logic       set_vbi;
		logic [7:0] vbi_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       line_valid;
		logic [7:0] active_line;
		logic       long_sync;
		logic       ps2_enabled;
		logic       post_start;
		logic [7:0] frame_count;
		logic [7:0] vbi_remaining;
		logic       ir_event;
		logic [7:0] ir_duration;
		logic       ir_prev_level;
	} out_word_t;

	typedef struct packed {
		logic [7:0] idx;
		logic [7:0] wdata;
	} cfg_word_t;

endpackage

### rtl/sfs_if.sv
// ----------------------------------------------------------------------------
// sfs channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------

// input word channel
interface sfs_in_if;
	logic              valid;
	logic              ready;
	sfs_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result word channel
interface sfs_out_if;
	logic               valid;
	logic               ready;
	sfs_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// register write channel
interface sfs_cfg_if;
	logic               valid;
	logic               ready;
	sfs_pkg::cfg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/scanline_field_sequencer_core.sv
// ----------------------------------------------------------------------------
// scanline_field_sequencer_core: vertical field timing, one word per line
// Four-phase field sequencer with frame count, VBI countdown, PS/2 enable
// and IR pulse timing.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per scanline tick (IR pin level, optional VBI load).
//   out_ch : one result word per input word, in order.
//   cfg    : register writes (index 0..3: sync, top blank, active, bottom
//            blank line counts); other indexes are ignored. Always ready.
//            Write only while no result is outstanding.
// Latency: the result word is valid the cycle after its input is taken.
// Throughput: one word per clock while out_ch.ready keeps up; all state
// updates are combinational between the input handshake and the result register.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready drops;
// nothing is lost or repeated.
// Reset: line counts return to 3/40/192/27, sequencer starts in bottom
// blank with one line left, counters clear, PS/2 enabled, no result pending.
// ----------------------------------------------------------------------------
module scanline_field_sequencer_core (
	input  logic clk,
	input  logic arst_n,
	sfs_in_if.sink     in_ch,
	sfs_out_if.source  out_ch,
	sfs_cfg_if.sink    cfg
);

	// configuration registers
	logic [7:0] sync_lines_q;
	logic [7:0] top_blank_lines_q;
	logic [7:0] active_lines_q;
	logic [7:0] bottom_blank_lines_q;

	// sequencer state
	sfs_pkg::phase_t phase_q;
	logic [7:0]      lines_left_q;
	logic [7:0]      field_counter_q;
	logic [7:0]      vbi_counter_q;
	logic            ps2_on_q;
	logic            ir_last_level_q;
	logic [7:0]      ir_lines_q;

	// result register
	logic               out_valid_q;
	sfs_pkg::out_word_t out_q;

	// next-state values
	sfs_pkg::phase_t    phase_d;
	logic [7:0]         lines_left_d;
	logic [7:0]         field_counter_d;
	logic [7:0]         vbi_counter_d;
	logic               ps2_on_d;
	logic [7:0]         ir_lines_d;
	logic [7:0]         vbi_base;
	logic [7:0]         lines_dec;
	logic               wrap;
	logic [7:0]         ir_base;
	sfs_pkg::out_word_t res;

	logic in_take;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_take     = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	function automatic sfs_pkg::phase_t next_phase(sfs_pkg::phase_t ph);
		case (ph)
			sfs_pkg::PH_SYNC:   next_phase = sfs_pkg::PH_TOP;
			sfs_pkg::PH_TOP:    next_phase = sfs_pkg::PH_ACTIVE;
			sfs_pkg::PH_ACTIVE: next_phase = sfs_pkg::PH_BOTTOM;
			default:            next_phase = sfs_pkg::PH_SYNC;
		endcase
	endfunction

	function automatic logic [1:0] phase_code(sfs_pkg::phase_t ph);
		case (ph)
			sfs_pkg::PH_SYNC:   phase_code = sfs_pkg::PH_CODE_SYNC;
			sfs_pkg::PH_TOP:    phase_code = sfs_pkg::PH_CODE_TOP;
			sfs_pkg::PH_ACTIVE: phase_code = sfs_pkg::PH_CODE_ACTIVE;
			default:            phase_code = sfs_pkg::PH_CODE_BOTTOM;
		endcase
	endfunction

	// line count loaded on entering a phase
	function automatic logic [7:0] phase_len(sfs_pkg::phase_t ph, logic [7:0] s,
		logic [7:0] t, logic [7:0] a, logic [7:0] b);
		case (ph)
			sfs_pkg::PH_SYNC:   phase_len = s;
			sfs_pkg::PH_TOP:    phase_len = t;
			sfs_pkg::PH_ACTIVE: phase_len = a;
			default:            phase_len = b;
		endcase
	endfunction

	// one scanline step
	always_comb begin
		vbi_base  = in_ch.data.set_vbi ? in_ch.data.vbi_value : vbi_counter_q;
		lines_dec = lines_left_q - 8'd1;
		wrap      = (lines_dec == 8'd0);

		phase_d         = phase_q;
		lines_left_d    = lines_dec;
		field_counter_d = field_counter_q;
		vbi_counter_d   = vbi_base;
		ps2_on_d        = ps2_on_q;
		res             = '0;

		res.line_valid = (phase_q == sfs_pkg::PH_ACTIVE);
		if (res.line_valid) begin
			res.active_line = active_lines_q - lines_left_q;
		end

		if (wrap) begin
			phase_d      = next_phase(phase_q);
			lines_left_d = phase_len(phase_d, sync_lines_q, top_blank_lines_q,
				active_lines_q, bottom_blank_lines_q);
			if (phase_d == sfs_pkg::PH_ACTIVE) begin
				ps2_on_d = 1'b0;
				if (vbi_base != 8'd0) begin
					vbi_counter_d = vbi_base - 8'd1;
				end
			end else if (phase_d == sfs_pkg::PH_BOTTOM) begin
				ps2_on_d        = 1'b1;
				field_counter_d = field_counter_q + 8'd1;
				res.post_start  = 1'b1;
			end
		end

		// IR level timing
		ir_base = ir_lines_q;
		if (in_ch.data.ir_level != ir_last_level_q) begin
			res.ir_event      = 1'b1;
			res.ir_duration   = ir_lines_q;
			res.ir_prev_level = ir_last_level_q;
			ir_base           = 8'd0;
		end
		ir_lines_d = (ir_base != sfs_pkg::IR_SAT) ? ir_base + 8'd1 : ir_base;

		res.phase         = phase_code(phase_d);
		res.long_sync     = (phase_d == sfs_pkg::PH_SYNC);
		res.ps2_enabled   = ps2_on_d;
		res.frame_count   = field_counter_d;
		res.vbi_remaining = vbi_counter_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_lines_q         <= sfs_pkg::RST_SYNC_LINES;
			top_blank_lines_q    <= sfs_pkg::RST_TOP_BLANK_LINES;
			active_lines_q       <= sfs_pkg::RST_ACTIVE_LINES;
			bottom_blank_lines_q <= sfs_pkg::RST_BOTTOM_BLANK_LINES;
		end else if (cfg.valid) begin
			case (cfg.data.idx)
				sfs_pkg::REG_SYNC_LINES:         sync_lines_q <= cfg.data.wdata;
				sfs_pkg::REG_TOP_BLANK_LINES:    top_blank_lines_q <= cfg.data.wdata;
				sfs_pkg::REG_ACTIVE_LINES:       active_lines_q <= cfg.data.wdata;
				sfs_pkg::REG_BOTTOM_BLANK_LINES: bottom_blank_lines_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= sfs_pkg::PH_BOTTOM;
			lines_left_q    <= 8'd1;
			field_counter_q <= 8'd0;
			vbi_counter_q   <= 8'd0;
			ps2_on_q        <= 1'b1;
			ir_last_level_q <= 1'b0;
			ir_lines_q      <= 8'd0;
		end else if (in_take) begin
			phase_q         <= phase_d;
			lines_left_q    <= lines_left_d;
			field_counter_q <= field_counter_d;
			vbi_counter_q   <= vbi_counter_d;
			ps2_on_q        <= ps2_on_d;
			ir_last_level_q <= in_ch.data.ir_level;
			ir_lines_q      <= ir_lines_d;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	// every taken word yields a result in the next cycle
	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> out_ch.valid)
		else $error("input word taken without result");

	// bottom blank entry always re-enables PS/2
	a_post_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.post_start |->
			out_ch.data.phase == sfs_pkg::PH_CODE_BOTTOM && out_ch.data.ps2_enabled)
		else $error("post_start outside bottom blank entry");

	// IR report fields are zero without an event
	a_ir_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.ir_event |->
			out_ch.data.ir_duration == 8'd0 && !out_ch.data.ir_prev_level)
		else $error("IR report without event");
`endif

endmodule

### tb/sv/tb_scanline_field_sequencer_core.sv
// ----------------------------------------------------------------------------
// tb_scanline_field_sequencer_core: self-checking bench for the field sequencer
// Feeds scanline words through the input channel under several line-count
// settings and idle patterns, predicts every result word from a behavioral
// copy of the sequencer and compares each field of the words that come out.
// ----------------------------------------------------------------------------
module tb_scanline_field_sequencer_core;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 150;

	logic clk;
	logic arst_n;

	sfs_in_if  in_ch ();
	sfs_out_if out_ch ();
	sfs_cfg_if cfg_ch ();

	scanline_field_sequencer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// words waiting to be sent, result words still owed by the block
	sfs_pkg::in_word_t  scan_ticks [$];
	sfs_pkg::out_word_t timing_words_due [$];

	// behavioral copy of the sequencer
	logic [7:0] len_cfg [4];
	logic [1:0] seq_phase;
	logic [7:0] seq_left;
	logic [7:0] field_cnt;
	logic [7:0] vbi_cnt;
	logic       ps2_en;
	logic       ir_level_last;
	logic [7:0] ir_run_lines;

	// stimulus shaping
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned stage;
	logic        gen_ir;
	int unsigned ir_run_left;

	// bookkeeping
	int unsigned mismatches;
	int unsigned words_checked;
	int unsigned fields_closed;
	int unsigned ir_saturated;
	int unsigned settings_used;
	int unsigned cycles;
	int unsigned hold_left;
	logic        hold_done;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one scanline tick of the sequencer; updates the copy, returns the word
	function automatic sfs_pkg::out_word_t advance_field_timing(sfs_pkg::in_word_t w);
		sfs_pkg::out_word_t r;
		r = '0;
		if (w.set_vbi)
			vbi_cnt = w.vbi_value;
		if (seq_phase == sfs_pkg::PH_CODE_ACTIVE) begin
			r.line_valid  = 1'b1;
			r.active_line = len_cfg[sfs_pkg::PH_CODE_ACTIVE] - seq_left;
		end
		// count down; a count of zero wraps to 255 without a phase change
		seq_left = seq_left - 8'd1;
		if (seq_left == 8'd0) begin
			seq_phase = seq_phase + 2'd1;
			seq_left  = len_cfg[seq_phase];
			if (seq_phase == sfs_pkg::PH_CODE_ACTIVE) begin
				ps2_en = 1'b0;
				if (vbi_cnt != 8'd0)
					vbi_cnt = vbi_cnt - 8'd1;
			end else if (seq_phase == sfs_pkg::PH_CODE_BOTTOM) begin
				ps2_en       = 1'b1;
				field_cnt    = field_cnt + 8'd1;
				r.post_start = 1'b1;
			end
		end
		// IR level timing, saturating duration
		if (w.ir_level != ir_level_last) begin
			r.ir_event      = 1'b1;
			r.ir_duration   = ir_run_lines;
			r.ir_prev_level = ir_level_last;
			ir_run_lines    = 8'd0;
			ir_level_last   = w.ir_level;
		end
		if (ir_run_lines != sfs_pkg::IR_SAT)
			ir_run_lines = ir_run_lines + 8'd1;
		r.phase         = seq_phase;
		r.long_sync     = (seq_phase == sfs_pkg::PH_CODE_SYNC);
		r.ps2_enabled   = ps2_en;
		r.frame_count   = field_cnt;
		r.vbi_remaining = vbi_cnt;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// random tick: IR held in runs, mostly short, sometimes past saturation
	function automatic sfs_pkg::in_word_t make_tick();
		sfs_pkg::in_word_t w;
		if (ir_run_left == 0) begin
			gen_ir      = ~gen_ir;
			ir_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 300)
				: $urandom_range(1, 12);
		end
		ir_run_left--;
		w.ir_level  = gen_ir;
		w.set_vbi   = ($urandom_range(0, 7) == 0);
		w.vbi_value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 5));
		return w;
	endfunction

	task automatic push_tick(logic ir, logic load, logic [7:0] val);
		sfs_pkg::in_word_t w;
		w.ir_level  = ir;
		w.set_vbi   = load;
		w.vbi_value = val;
		scan_ticks.push_back(w);
	endtask

	// register write; the copy follows the handshake
	task automatic write_reg(logic [7:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_ch.data.idx   <= idx;
		cfg_ch.data.wdata <= val;
		cfg_ch.valid      <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			sfs_pkg::REG_SYNC_LINES, sfs_pkg::REG_TOP_BLANK_LINES,
			sfs_pkg::REG_ACTIVE_LINES,
			sfs_pkg::REG_BOTTOM_BLANK_LINES: len_cfg[idx[1:0]] = val;
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic program_lengths(logic [7:0] s, logic [7:0] t, logic [7:0] a,
			logic [7:0] b);
		write_reg(sfs_pkg::REG_SYNC_LINES, s);
		write_reg(sfs_pkg::REG_TOP_BLANK_LINES, t);
		write_reg(sfs_pkg::REG_ACTIVE_LINES, a);
		write_reg(sfs_pkg::REG_BOTTOM_BLANK_LINES, b);
		settings_used++;
	endtask

	// wait until every queued word went in and every result came out;
	// sampled at the falling edge so the driver's updates have landed
	task automatic settle();
		do @(negedge clk);
		while (scan_ticks.size() != 0 || in_ch.valid || timing_words_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_random(int unsigned n);
		repeat (n) scan_ticks.push_back(make_tick());
		settle();
	endtask

	// input driver: takes words from the queue, predicts on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				timing_words_due.push_back(advance_field_timing(in_ch.data));
			if (!in_ch.valid || in_ch.ready) begin
				if (scan_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_ch.data  <= scan_ticks.pop_front();
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold in the last stage so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (stage == 5 && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		sfs_pkg::out_word_t want;
		sfs_pkg::out_word_t got;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (timing_words_due.size() == 0) begin
					$error("result word with nothing outstanding: %h", got);
					mismatches++;
				end else begin
					want = timing_words_due.pop_front();
					check_field("phase", want.phase, got.phase);
					check_field("line_valid", want.line_valid, got.line_valid);
					check_field("active_line", want.active_line, got.active_line);
					check_field("long_sync", want.long_sync, got.long_sync);
					check_field("ps2_enabled", want.ps2_enabled, got.ps2_enabled);
					check_field("post_start", want.post_start, got.post_start);
					check_field("frame_count", want.frame_count, got.frame_count);
					check_field("vbi_remaining", want.vbi_remaining, got.vbi_remaining);
					check_field("ir_event", want.ir_event, got.ir_event);
					check_field("ir_duration", want.ir_duration, got.ir_duration);
					check_field("ir_prev_level", want.ir_prev_level, got.ir_prev_level);
					words_checked++;
					if (want.post_start)
						fields_closed++;
					if (want.ir_event && want.ir_duration == sfs_pkg::IR_SAT)
						ir_saturated++;
				end
			end
			if (hold_left != 0)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// run length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;

		// sequencer copy at reset
		len_cfg[2'(sfs_pkg::REG_SYNC_LINES)]         = sfs_pkg::RST_SYNC_LINES;
		len_cfg[2'(sfs_pkg::REG_TOP_BLANK_LINES)]    = sfs_pkg::RST_TOP_BLANK_LINES;
		len_cfg[2'(sfs_pkg::REG_ACTIVE_LINES)]       = sfs_pkg::RST_ACTIVE_LINES;
		len_cfg[2'(sfs_pkg::REG_BOTTOM_BLANK_LINES)] = sfs_pkg::RST_BOTTOM_BLANK_LINES;
		seq_phase     = sfs_pkg::PH_CODE_BOTTOM;
		seq_left      = 8'd1;
		field_cnt     = 8'd0;
		vbi_cnt       = 8'd0;
		ps2_en        = 1'b1;
		ir_level_last = 1'b0;
		ir_run_lines  = 8'd0;

		send_idle_pct = 9;
		recv_idle_pct = 82;
		stage         = 0;
		gen_ir        = 1'b0;
		ir_run_left   = 270;
		mismatches    = 0;
		words_checked = 0;
		fields_closed = 0;
		ir_saturated  = 0;
		settings_used = 1;
		cycles        = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset line counts, VBI load extremes, IR toggles
		push_tick(1'b0, 1'b0, 8'h00);
		push_tick(1'b1, 1'b0, 8'h00);
		push_tick(1'b0, 1'b1, 8'hFF);
		push_tick(1'b1, 1'b1, 8'h00);
		push_tick(1'b1, 1'b1, 8'hAA);
		push_tick(1'b1, 1'b1, 8'h55);
		settle();

		// directed: short field, stray register indexes ignored
		program_lengths(8'd1, 8'd2, 8'd3, 8'd1);
		write_reg(8'd4, 8'd0);
		write_reg(8'hFF, 8'd7);
		push_tick(1'b0, 1'b1, 8'd2);
		push_tick(1'b0, 1'b0, 8'd0);
		push_tick(1'b0, 1'b1, 8'd1);
		push_tick(1'b1, 1'b0, 8'hFF);
		push_tick(1'b0, 1'b1, 8'd3);
		push_tick(1'b1, 1'b0, 8'd0);
		push_tick(1'b1, 1'b1, 8'd0);
		push_tick(1'b0, 1'b0, 8'd0);
		push_tick(1'b0, 1'b1, 8'd1);
		push_tick(1'b1, 1'b1, 8'd1);
		push_tick(1'b1, 1'b0, 8'd0);
		push_tick(1'b0, 1'b0, 8'd0);
		push_tick(1'b1, 1'b1, 8'd9);
		push_tick(1'b1, 1'b0, 8'd0);
		push_tick(1'b0, 1'b0, 8'd0);
		push_tick(1'b0, 1'b0, 8'd0);
		settle();

		// shortest fields, receiver mostly stalled
		program_lengths(8'd1, 8'd1, 8'd1, 8'd1);
		run_random(150);

		stage = 1;
		program_lengths(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
			8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
		run_random(150);

		// longest phases, sender mostly idle
		stage         = 2;
		send_idle_pct = 82;
		recv_idle_pct = 9;
		program_lengths(8'd2, 8'd1, 8'd255, 8'd255);
		run_random(180);

		stage = 3;
		program_lengths(8'd255, 8'd255, 8'd3, 8'd1);
		run_random(150);

		// zero active count: 256-line phase, wrapping line index
		stage         = 4;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		ir_run_left   = 280;
		program_lengths(8'd1, 8'd1, 8'd0, 8'd1);
		run_random(280);

		// no idling, one long receiver hold
		program_lengths(8'($urandom_range(1, 6)), 8'($urandom_range(0, 6)),
			8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
		stage = 5;
		run_random(165);

		$display("%0d result words checked under %0d line-count settings", words_checked,
			settings_used);
		$display("%0d fields closed, %0d saturated IR durations reported", fields_closed,
			ir_saturated);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
